>>> src/h264_rtp_depacketizer_top_defines.svh
// assertion macros for the h264 rtp depacketizer
`ifndef H264_RTP_DEPACKETIZER_TOP_DEFINES_SVH
`define H264_RTP_DEPACKETIZER_TOP_DEFINES_SVH

// checked property, held off while reset is asserted
`define H264D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property, also evaluated during reset
`define H264D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/h264d_pkg.sv
// shared types and constants for the h264 rtp depacketizer
`default_nettype none
package h264d_pkg;

  localparam int unsigned BYTE_W = 8;

  // start code 00 00 00 01, emitted as a countdown
  localparam logic [2:0]        SC_LEN       = 3'd4;
  localparam logic [BYTE_W-1:0] SC_ZERO_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] SC_LAST_BYTE = 8'h01;

  // one run of results caused by one input transaction
  typedef struct packed {
    logic              start_code;
    logic              byte_vld;
    logic [BYTE_W-1:0] data;
    logic              nal_end;
  } run_t;

  // emitter status seen by the top level
  typedef struct packed {
    logic busy;
    logic pop;
    logic pop_last;
  } emit_stat_t;

endpackage
`default_nettype wire

>>> src/h264d_if.sv
// stream channel interfaces for the h264 rtp depacketizer
`default_nettype none
interface h264d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_packet;
  logic       last_of_packet;

  modport source (output valid, output data_byte, output first_of_packet,
                  output last_of_packet, input ready);
  modport sink (input valid, input data_byte, input first_of_packet,
                input last_of_packet, output ready);
endinterface

interface h264d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       nal_end;
  logic       last_of_run;

  modport source (output valid, output out_byte, output nal_end,
                  output last_of_run, input ready);
  modport sink (input valid, input out_byte, input nal_end,
                input last_of_run, output ready);
endinterface
`default_nettype wire

>>> src/h264_rtp_depacketizer_top.sv
// top level of the h264 rtp depacketizer
// Converts RTP H.264 payload bytes (RFC 6184 single NAL, STAP-A and FU-A)
// into an Annex-B byte stream, one input byte per transaction and one
// output byte per transaction. Each input byte is decoded in the cycle it
// is accepted and yields a run of zero to five output bytes: an optional
// 00 00 00 01 start code followed by an optional payload or rebuilt NAL
// header byte. The run sits in a small buffer that drains through a
// registered output stage at one byte per cycle while the output is
// ready, and the next input byte is taken in the cycle the final byte
// of the run drains. With the output always ready, plain payload bytes
// stream at one per cycle with no bubble; a byte that opens a NAL unit
// with its header (single NAL indicator, FU-A start header) or a STAP-A
// low size byte that opens a unit holds off the input while its start
// code drains. A byte that produces nothing (STAP-A high size byte,
// empty or cut-off unit size, FU indicator, FU header without the start
// bit, dropped packet types, bytes outside a packet) does not hold off
// the next. An output stall with a byte waiting holds the drain. The
// first byte of a run passes the run buffer, then the output register.
// last_of_run marks the final output byte of each input transaction,
// nal_end the last byte of a complete NAL unit. No clearing pass after reset.
`default_nettype none
`include "h264_rtp_depacketizer_top_defines.svh"
module h264_rtp_depacketizer_top
  import h264d_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  h264d_in_if.sink    in_if,
  h264d_out_if.source out_if
);

  run_t       run;
  emit_stat_t stat;
  logic       in_accept;
  logic       out_end_vld;
  logic       out_mid_run;
  logic       out_sc_byte;
  logic       in_over_run;

  // input is taken when the run buffer is empty or drains its final byte now
  assign in_if.ready = !stat.busy || stat.pop_last;
  assign in_accept   = in_if.valid && in_if.ready;

  // packet parsing state and per-byte decode
  h264d_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_accept),
    .data_byte       (in_if.data_byte),
    .first_of_packet (in_if.first_of_packet),
    .last_of_packet  (in_if.last_of_packet),
    .run             (run)
  );

  // start code insertion and output register
  h264d_emitter u_emitter (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (in_accept),
    .run         (run),
    .out_ready   (out_if.ready),
    .out_valid   (out_if.valid),
    .out_byte    (out_if.out_byte),
    .out_nal_end (out_if.nal_end),
    .out_last    (out_if.last_of_run),
    .stat        (stat)
  );

  // terms for the checks below
  assign out_end_vld = out_if.valid && out_if.nal_end;
  assign out_mid_run = out_if.valid && !out_if.last_of_run;
  assign out_sc_byte = (out_if.out_byte == SC_ZERO_BYTE) || (out_if.out_byte == SC_LAST_BYTE);
  assign in_over_run = in_accept && stat.busy && !stat.pop_last;

  // a completed nal unit always closes the run of its input byte
  `H264D_ASSERT(a_nal_end_closes_run, out_end_vld |-> out_if.last_of_run, "nal_end mid run")

  // bytes ahead of the last in a run are start code bytes only
  `H264D_ASSERT(a_inner_sc, out_mid_run |-> out_sc_byte && !out_if.nal_end, "data byte in run")

  // input is never taken while the run buffer still holds more than one byte
  `H264D_ASSERT_ALWAYS(a_no_overrun, !rst_n || !in_over_run, "accepted over a pending run")

endmodule
`default_nettype wire

>>> src/h264d_parser.sv
// packet parser: rtp h264 payload state and run decode
`default_nettype none
module h264d_parser
  import h264d_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              first_of_packet,
  input  wire logic              last_of_packet,
  output run_t                   run
);

  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_SINGLE    = 3'd1;
  localparam logic [2:0] MODE_STAP_HI   = 3'd2;
  localparam logic [2:0] MODE_STAP_LO   = 3'd3;
  localparam logic [2:0] MODE_STAP_DATA = 3'd4;
  localparam logic [2:0] MODE_FU_HDR    = 3'd5;
  localparam logic [2:0] MODE_FU_DATA   = 3'd6;

  localparam logic [4:0] TYPE_SINGLE_MIN = 5'd1;
  localparam logic [4:0] TYPE_SINGLE_MAX = 5'd23;
  localparam logic [4:0] TYPE_STAP_A     = 5'd24;
  localparam logic [4:0] TYPE_FU_A       = 5'd28;

  logic [2:0]        mode_r, mode_nxt;
  logic [15:0]       remain_r, remain_nxt;
  logic [BYTE_W-1:0] size_hi_r, size_hi_nxt;
  logic [2:0]        f_nri_r, f_nri_nxt;
  logic              frag_end_r, frag_end_nxt;
  logic [4:0]        hdr_type;
  logic [15:0]       size_full;
  logic [15:0]       remain_dec;

  assign hdr_type   = data_byte[4:0];
  assign size_full  = {size_hi_r, data_byte};
  assign remain_dec = remain_r - 16'd1;

  always_comb begin
    mode_nxt       = mode_r;
    remain_nxt     = remain_r;
    size_hi_nxt    = size_hi_r;
    f_nri_nxt      = f_nri_r;
    frag_end_nxt   = frag_end_r;
    run.start_code = 1'b0;
    run.byte_vld   = 1'b0;
    run.data       = data_byte;
    run.nal_end    = 1'b0;
    if (first_of_packet) begin
      priority if (hdr_type >= TYPE_SINGLE_MIN && hdr_type <= TYPE_SINGLE_MAX) begin
        run.start_code = 1'b1;
        run.byte_vld   = 1'b1;
        run.nal_end    = last_of_packet;
        mode_nxt       = last_of_packet ? MODE_IDLE : MODE_SINGLE;
      end else if (hdr_type == TYPE_STAP_A) begin
        mode_nxt = last_of_packet ? MODE_IDLE : MODE_STAP_HI;
      end else if (hdr_type == TYPE_FU_A) begin
        f_nri_nxt    = data_byte[7:5];
        frag_end_nxt = 1'b0;
        mode_nxt     = last_of_packet ? MODE_IDLE : MODE_FU_HDR;
      end else begin
        mode_nxt = MODE_IDLE;
      end
    end else begin
      unique case (mode_r)
        MODE_SINGLE: begin
          run.byte_vld = 1'b1;
          run.nal_end  = last_of_packet;
        end
        MODE_STAP_HI: begin
          size_hi_nxt = data_byte;
          mode_nxt    = MODE_STAP_LO;
        end
        MODE_STAP_LO: begin
          remain_nxt = size_full;
          if (size_full != 16'd0 && !last_of_packet) begin
            run.start_code = 1'b1;
            mode_nxt       = MODE_STAP_DATA;
          end else begin
            mode_nxt = MODE_STAP_HI;
          end
        end
        MODE_STAP_DATA: begin
          remain_nxt   = remain_dec;
          run.byte_vld = 1'b1;
          run.nal_end  = (remain_dec == 16'd0);
          if (remain_dec == 16'd0) begin
            mode_nxt = MODE_STAP_HI;
          end
        end
        MODE_FU_HDR: begin
          frag_end_nxt = data_byte[6];
          if (data_byte[7]) begin
            // rebuilt nal header: f and nri from the indicator, type from fu header
            run.start_code = 1'b1;
            run.byte_vld   = 1'b1;
            run.data       = {f_nri_r, data_byte[4:0]};
            run.nal_end    = last_of_packet & data_byte[6];
          end
          mode_nxt = MODE_FU_DATA;
        end
        MODE_FU_DATA: begin
          run.byte_vld = 1'b1;
          run.nal_end  = last_of_packet & frag_end_r;
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
      if (last_of_packet) begin
        mode_nxt = MODE_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      remain_r   <= 16'd0;
      size_hi_r  <= '0;
      f_nri_r    <= 3'd0;
      frag_end_r <= 1'b0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      remain_r   <= remain_nxt;
      size_hi_r  <= size_hi_nxt;
      f_nri_r    <= f_nri_nxt;
      frag_end_r <= frag_end_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/h264d_emitter.sv
// run buffer and output register, one stream byte per cycle while the output is ready
`default_nettype none
module h264d_emitter
  import h264d_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire run_t              run,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_nal_end,
  output logic                   out_last,
  output emit_stat_t             stat
);

  logic [2:0]        sc_left_r, sc_left_nxt;
  logic              bv_r, bv_nxt;
  logic [BYTE_W-1:0] data_r;
  logic              end_r;
  logic              out_vld_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_end_r;
  logic              out_last_r;

  logic [BYTE_W-1:0] cur_byte;
  logic              cur_end;
  logic              cur_last;

  // current element of the run: start code countdown, then the data byte
  always_comb begin
    if (sc_left_r != 3'd0) begin
      cur_byte = (sc_left_r == 3'd1) ? SC_LAST_BYTE : SC_ZERO_BYTE;
      cur_end  = 1'b0;
      cur_last = (sc_left_r == 3'd1) && !bv_r;
    end else begin
      cur_byte = data_r;
      cur_end  = end_r;
      cur_last = 1'b1;
    end
  end

  assign stat.busy     = (sc_left_r != 3'd0) || bv_r;
  assign stat.pop      = stat.busy && (!out_vld_r || out_ready);
  assign stat.pop_last = stat.pop && cur_last;

  always_comb begin
    sc_left_nxt = sc_left_r;
    bv_nxt      = bv_r;
    if (stat.pop) begin
      if (sc_left_r != 3'd0) begin
        sc_left_nxt = sc_left_r - 3'd1;
      end else begin
        bv_nxt = 1'b0;
      end
    end
    if (load) begin
      sc_left_nxt = run.start_code ? SC_LEN : 3'd0;
      bv_nxt      = run.byte_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_left_r <= 3'd0;
      bv_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      sc_left_r <= sc_left_nxt;
      bv_r      <= bv_nxt;
      if (stat.pop) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= run.data;
      end_r  <= run.nal_end;
    end
    if (stat.pop) begin
      out_byte_r <= cur_byte;
      out_end_r  <= cur_end;
      out_last_r <= cur_last;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_byte    = out_byte_r;
  assign out_nal_end = out_end_r;
  assign out_last    = out_last_r;

endmodule
`default_nettype wire
